>>> design/gef_pkg.sv
`default_nettype none

package gef_pkg;

  // Frame limits and derived widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);    // column counters, line store address
  localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);   // output row counter
  localparam int ROW_W      = OUT_ROW_W + 1;        // input row runs one past the frame on drain

  // Register field widths
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;

  // Request types
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Register indexes on the APB port
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // Per-request control, decided at accept time from the raster counters
  typedef struct packed {
    logic             keep;         // request changes state (not an early drain)
    logic             write;        // pixel inside the frame: store its gray value
    logic             produce;      // request releases one result
    logic             last;         // result is the final one of the frame
    logic [COL_W-1:0] col;          // input column, line store address
    logic             top_zero;
    logic             bottom_zero;
    logic             left_zero;
    logic             right_zero;
  } item_t;

  // One line store word: gray of the same column two rows up and one row up
  typedef struct packed {
    logic [7:0] older;
    logic [7:0] newer;
  } line_word_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_word_t       data;
  } line_wr_t;

  // One window column, top to bottom
  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } tap_col_t;

endpackage

`default_nettype wire

>>> design/gef_ctrl.sv
`default_nettype none

module gef_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  input  wire logic                 accept,
  input  wire logic                 req_type,
  output gef_pkg::item_t            item
);

  logic [gef_pkg::WIDTH_W-1:0]   frame_width;
  logic [gef_pkg::HEIGHT_W-1:0]  frame_height;
  logic [gef_pkg::WIDTH_W-1:0]   w_eff;
  logic [gef_pkg::HEIGHT_W-1:0]  h_eff;

  logic [gef_pkg::COL_W-1:0]     in_column, in_column_next;
  logic [gef_pkg::ROW_W-1:0]     in_row, in_row_next;
  logic [gef_pkg::COL_W-1:0]     out_column, out_column_next;
  logic [gef_pkg::OUT_ROW_W-1:0] out_row, out_row_next;

  logic cfg_we;
  logic in_frame;
  logic in_col_wrap;
  logic out_col_end;
  logic out_row_end;

  assign cfg_we = psel && penable && pwrite;

  // Zero reads as one, oversize saturates
  always_comb begin
    if (frame_width == '0) begin
      w_eff = gef_pkg::WIDTH_W'(1);
    end else if (frame_width > gef_pkg::WIDTH_W'(gef_pkg::MAX_WIDTH)) begin
      w_eff = gef_pkg::WIDTH_W'(gef_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = gef_pkg::HEIGHT_W'(1);
    end else if (frame_height > gef_pkg::HEIGHT_W'(gef_pkg::MAX_HEIGHT)) begin
      h_eff = gef_pkg::HEIGHT_W'(gef_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  always_comb begin
    case (gef_pkg::reg_index_t'(paddr[2]))
      gef_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      gef_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  assign in_frame    = gef_pkg::HEIGHT_W'(in_row) < h_eff;
  assign in_col_wrap = ({1'b0, in_column} + gef_pkg::WIDTH_W'(1)) >= w_eff;
  assign out_col_end = ({1'b0, out_column} + gef_pkg::WIDTH_W'(1)) >= w_eff;
  assign out_row_end = ({1'b0, out_row} + gef_pkg::HEIGHT_W'(1)) >= h_eff;

  // Decode for the request now at the input
  always_comb begin
    item.keep        = !(in_frame && (req_type == gef_pkg::REQ_DRAIN));
    item.write       = in_frame;
    // raster index >= width + 1
    item.produce     = (in_row >= gef_pkg::ROW_W'(2)) ||
                       ((in_row == gef_pkg::ROW_W'(1)) && (in_column != '0));
    item.last        = out_row_end && out_col_end;
    item.col         = in_column;
    item.top_zero    = (out_row == '0);
    item.bottom_zero = out_row_end;
    item.left_zero   = (out_column == '0);
    item.right_zero  = out_col_end;
  end

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (accept && item.keep) begin
      if (in_col_wrap) begin
        in_column_next = '0;
        in_row_next    = in_row + gef_pkg::ROW_W'(1);
      end else begin
        in_column_next = in_column + gef_pkg::COL_W'(1);
      end
      if (item.produce) begin
        if (item.last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (out_col_end) begin
          out_column_next = '0;
          out_row_next    = out_row + gef_pkg::OUT_ROW_W'(1);
        end else begin
          out_column_next = out_column + gef_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gef_pkg::WIDTH_W'(1024);
      frame_height <= gef_pkg::HEIGHT_W'(768);
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
    end else if (cfg_we) begin
      case (gef_pkg::reg_index_t'(paddr[2]))
        gef_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[gef_pkg::WIDTH_W-1:0];
        gef_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[gef_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  a_in_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_column} < w_eff)
    else $error("input column beyond frame width");

  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, out_column} < w_eff)
    else $error("output column beyond frame width");

endmodule

`default_nettype wire

>>> design/gef_line_store.sv
`default_nettype none

module gef_line_store (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [gef_pkg::COL_W-1:0] rd_addr,
  input  wire gef_pkg::line_wr_t         wr,
  output gef_pkg::line_word_t            rd_data
);

  gef_pkg::line_word_t mem [gef_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Same-column write in the same cycle only happens at width one
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/gef_window.sv
`default_nettype none

module gef_window (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire gef_pkg::item_t      load_item,
  input  wire logic [7:0]          load_gray,
  input  wire gef_pkg::line_word_t rd_data,
  output logic                     load_ok,
  output gef_pkg::line_wr_t        wr,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic [7:0]               emboss_value,
  output logic                     last_of_frame
);

  logic               b_valid;
  gef_pkg::item_t     b_item;
  logic [7:0]         b_gray;
  logic               b_go;
  logic               o_free;

  gef_pkg::tap_col_t  prev1;
  gef_pkg::tap_col_t  prev2;
  gef_pkg::tap_col_t  incoming;

  logic [7:0] t00, t01, t02, t10, t11, t12, t20, t21, t22;
  logic [10:0]        pos, neg;
  logic signed [11:0] sum;
  logic [7:0]         clamped;

  assign o_free  = !res_valid || res_ready;
  assign b_go    = b_valid && (!b_item.produce || o_free);
  assign load_ok = !b_valid || b_go;

  assign incoming.top = rd_data.older;
  assign incoming.mid = rd_data.newer;
  assign incoming.bot = b_gray;

  // line shift: newer moves to older, new gray becomes newer
  assign wr.en        = b_go && b_item.write;
  assign wr.addr      = b_item.col;
  assign wr.data.older = rd_data.newer;
  assign wr.data.newer = b_gray;

  always_comb begin
    t00 = (b_item.top_zero    || b_item.left_zero)  ? 8'd0 : prev2.top;
    t01 =  b_item.top_zero                          ? 8'd0 : prev1.top;
    t02 = (b_item.top_zero    || b_item.right_zero) ? 8'd0 : incoming.top;
    t10 =  b_item.left_zero                         ? 8'd0 : prev2.mid;
    t11 =  prev1.mid;
    t12 =  b_item.right_zero                        ? 8'd0 : incoming.mid;
    t20 = (b_item.bottom_zero || b_item.left_zero)  ? 8'd0 : prev2.bot;
    t21 =  b_item.bottom_zero                       ? 8'd0 : prev1.bot;
    t22 = (b_item.bottom_zero || b_item.right_zero) ? 8'd0 : incoming.bot;
  end

  // kernel [-2 -1 0; -1 1 1; 0 1 2]; t02 and t20 carry zero weight
  always_comb begin
    pos = 11'(t11) + 11'(t12) + 11'(t21) + {2'b0, t22, 1'b0};
    neg = {2'b0, t00, 1'b0} + 11'(t01) + 11'(t10) + 11'(t02 & 8'd0) + 11'(t20 & 8'd0);
    sum = $signed({1'b0, pos}) - $signed({1'b0, neg});
    if (sum < 12'sd0) begin
      clamped = 8'd0;
    end else if (sum > 12'sd255) begin
      clamped = 8'd255;
    end else begin
      clamped = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (load) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_item <= load_item;
      b_gray <= load_gray;
    end
    if (b_go) begin
      prev2 <= prev1;
      prev1 <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_go && b_item.produce) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_item.produce) begin
      emboss_value  <= clamped;
      last_of_frame <= b_item.last;
    end
  end

  a_b_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_go |=> b_valid && $stable(b_item) && $stable(b_gray))
    else $error("window stage lost its request while stalled");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> load_ok)
    else $error("window stage loaded while occupied");

endmodule

`default_nettype wire

>>> design/gray_emboss_3x3_filter.sv
`default_nettype none

// 3x3 emboss filter on the luma of an RGB raster stream. Each pixel request is
// turned into gray = (13933*R + 46871*G + 4732*B) >> 16, and every output is the
// kernel [-2 -1 0; -1 1 1; 0 1 2] over the gray neighborhood, taps off the frame
// reading as zero, clamped to 0..255. Requests are accepted one per clock when the
// result side keeps up; the pipeline is three registers deep (input stage,
// window stage with the registered line store read, result register); a request
// passes through the input and window stages; its result is registered, raising
// res_valid. Results lag the input by frame_width + 1 requests; after the last
// pixel of a frame send frame_width + 1 drain requests (req_type = 1) to flush
// the final row. A drain request before the frame is complete is taken and
// ignored; a pixel after the frame is complete counts as a drain. last_of_frame
// marks the final result, after which counting restarts. frame_width (0x0) and
// frame_height (0x4) must be written only while idle; the block does not
// enforce it. Any write restarts the frame. Zero reads as one, values above
// 1024 columns or 4096 rows saturate. The two gray lines sit in one 1024 x 16
// memory with one read and one write per cycle; it needs no clearing pass.
module gray_emboss_3x3_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // pixel requests
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  // results
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [7:0]       emboss_value,
  output logic             last_of_frame
);

  // input stage
  logic                a_valid;
  gef_pkg::item_t      a_item;
  logic [7:0]          a_red, a_green, a_blue;
  logic                a_go;
  logic [23:0]         luma_sum;
  logic [7:0]          a_gray;

  logic                accept;
  gef_pkg::item_t      head_item;
  logic                win_ok;
  gef_pkg::line_word_t rd_data;
  gef_pkg::line_wr_t   wr;

  assign pready    = 1'b1;
  assign accept    = req_valid && req_ready;
  assign a_go      = a_valid && win_ok;
  assign req_ready = !a_valid || a_go;

  // Q0.16 luma weights, truncated; the sum never exceeds 24 bits
  assign luma_sum = 24'(a_red)   * 24'd13933 +
                    24'(a_green) * 24'd46871 +
                    24'(a_blue)  * 24'd4732;
  assign a_gray   = luma_sum[23:16];

  gef_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .accept   (accept),
    .req_type (req_type),
    .item     (head_item)
  );

  // Early drain requests are dropped here and never enter the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= head_item.keep;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item  <= head_item;
      a_red   <= red;
      a_green <= green;
      a_blue  <= blue;
    end
  end

  // read is issued as the request moves into the window stage
  gef_line_store u_line_store (
    .clk     (clk),
    .rd_en   (a_go),
    .rd_addr (a_item.col),
    .wr      (wr),
    .rd_data (rd_data)
  );

  gef_window u_window (
    .clk           (clk),
    .rst           (rst),
    .load          (a_go),
    .load_item     (a_item),
    .load_gray     (a_gray),
    .rd_data       (rd_data),
    .load_ok       (win_ok),
    .wr            (wr),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .emboss_value  (emboss_value),
    .last_of_frame (last_of_frame)
  );

  a_a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_go |=> a_valid && $stable(a_item) && $stable(a_red))
    else $error("input stage lost its request while stalled");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Line history depth: two full rows plus the three taps of the newest column
  localparam int GRAY_DEPTH    = 2 * gef_pkg::MAX_WIDTH + 3;
  // Pipeline is three registers deep; leave some slack before touching registers
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 50000;
  localparam int RANDOM_ITEMS  = 560;
  localparam int QUIET_ITEMS   = 200;
  localparam int IDLE_PCT      = 31;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } emboss_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        req_type = gef_pkg::REQ_PIXEL;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;

  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [7:0]  emboss_value;
  logic        last_of_frame;

  gray_emboss_3x3_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_type     (req_type),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .emboss_value (emboss_value),
    .last_of_frame(last_of_frame)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Emboss predictor: register copy, gray history and raster counters
  // ---------------------------------------------------------------------------
  logic [gef_pkg::WIDTH_W-1:0]   cfg_width  = gef_pkg::WIDTH_W'(1024);
  logic [gef_pkg::HEIGHT_W-1:0]  cfg_height = gef_pkg::HEIGHT_W'(768);
  logic [7:0]                    gray_history [0:GRAY_DEPTH-1];
  logic [gef_pkg::COL_W-1:0]     in_col  = '0;
  logic [gef_pkg::ROW_W-1:0]     in_row  = '0;
  logic [gef_pkg::COL_W-1:0]     out_col = '0;
  logic [gef_pkg::OUT_ROW_W-1:0] out_row = '0;

  emboss_result_t expected_emboss [$];
  emboss_result_t want;

  int  error_count    = 0;
  int  accepted_items = 0;
  int  cycle_count    = 0;
  bit  idle_on        = 1'b1;   // random idling on both channels
  bit  req_held       = 1'b0;   // valid still high after the last accept

  initial begin
    for (int i = 0; i < GRAY_DEPTH; i++) gray_history[i] = '0;
  end

  // zero reads as one, oversize saturates
  function automatic int active_width();
    if (cfg_width == 0) return 1;
    if (int'(cfg_width) > gef_pkg::MAX_WIDTH) return gef_pkg::MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  function automatic int active_height();
    if (cfg_height == 0) return 1;
    if (int'(cfg_height) > gef_pkg::MAX_HEIGHT) return gef_pkg::MAX_HEIGHT;
    return int'(cfg_height);
  endfunction

  function automatic void restart_raster();
    in_col  = '0;
    in_row  = '0;
    out_col = '0;
    out_row = '0;
  endfunction

  // Applies one accepted request. Returns 0 if the block ignores it
  // (drain tick while the frame is still coming in).
  function automatic bit predict_emboss(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, h, n, gray, sum, ty, tx, v, wt;
    bit row_ok, col_ok, last;
    emboss_result_t res;
    w = active_width();
    h = active_height();
    n = int'(in_row) * w + int'(in_col);
    if (int'(in_row) < h) begin
      if (kind == gef_pkg::REQ_DRAIN) return 1'b0;
      gray = (13933 * int'(r) + 46871 * int'(g) + 4732 * int'(b)) >> 16;
      gray_history[n % GRAY_DEPTH] = gray[7:0];
    end
    // past the last row the input counters keep running (drain)
    if (int'(in_col) + 1 >= w) begin
      in_col = '0;
      in_row = in_row + 1'b1;
    end else begin
      in_col = in_col + 1'b1;
    end
    // output lags one row plus one pixel
    if (n < w + 1) return 1'b1;

    sum = 0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        row_ok = !(dy == 0 && out_row == 0) && !(dy == 2 && int'(out_row) + 1 >= h);
        col_ok = !(dx == 0 && out_col == 0) && !(dx == 2 && int'(out_col) + 1 >= w);
        v = 0;
        if (row_ok && col_ok) begin
          ty = int'(out_row) + dy - 1;
          tx = int'(out_col) + dx - 1;
          v  = int'(gray_history[(ty * w + tx) % GRAY_DEPTH]);
        end
        // kernel [-2 -1 0; -1 1 1; 0 1 2]
        case (dy * 3 + dx)
          0:       wt = -2;
          1, 3:    wt = -1;
          4, 5, 7: wt = 1;
          8:       wt = 2;
          default: wt = 0;
        endcase
        sum += v * wt;
      end
    end
    if (sum < 0) sum = 0;
    else if (sum > 255) sum = 255;

    last = (int'(out_row) + 1 >= h) && (int'(out_col) + 1 >= w);
    res.value = sum[7:0];
    res.last  = last;
    expected_emboss.push_back(res);

    if (last) begin
      restart_raster();
    end else if (int'(out_col) + 1 >= w) begin
      out_col = '0;
      out_row = out_row + 1'b1;
    end else begin
      out_col = out_col + 1'b1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    logic [31:0] word;
    word = $urandom();
    return word[7:0];
  endfunction

  // register value with random junk above the field
  function automatic logic [31:0] field_word(int value, int bits);
    logic [31:0] word;
    word = $urandom();
    for (int i = 0; i < bits; i++) word[i] = value[i];
    return word;
  endfunction

  // One request through the valid/ready handshake, then into the predictor.
  // Valid stays high after the accept so a back-to-back request needs no
  // second assignment in that step; an idle gap lowers it first.
  task automatic send_request(input logic kind, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      if (req_held) req_valid <= 1'b0;
      req_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    red       <= r;
    green     <= g;
    blue      <= b;
    do @(posedge clk); while (!req_ready);
    req_held = 1'b1;
    if (predict_emboss(kind, r, g, b)) accepted_items++;
  endtask

  // Drop valid after the last accept, then wait on the clock so nothing else
  // drives valid in the same step.
  task automatic release_requests();
    if (req_held) begin
      req_valid <= 1'b0;
      req_held = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    release_requests();
    while (expected_emboss.size() != 0) @(posedge clk);
  endtask

  // Idle point: all results out, then a few cycles for requests that
  // released nothing but may still be moving through the pipe.
  task automatic settle_block();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready. Any write restarts the frame.
  task automatic write_register(input gef_pkg::reg_index_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == gef_pkg::REG_FRAME_WIDTH) cfg_width = data[gef_pkg::WIDTH_W-1:0];
    else cfg_height = data[gef_pkg::HEIGHT_W-1:0];
    restart_raster();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // APB read: setup cycle, then access; data taken at the access edge
  task automatic read_register(input gef_pkg::reg_index_t idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One frame of random pixels at the current geometry, then the drain.
  // stop_after < 0 sends the whole frame; otherwise the frame may be cut short
  // (no drain then). Noise: stray drain ticks mid-frame, pixels in the drain.
  task automatic stream_frame(input int stop_after, input int noise_pct, input bit hold_midway,
                              output bit finished);
    int w, h, total, count;
    w = active_width();
    h = active_height();
    total = w * h;
    count = (stop_after < 0 || stop_after > total) ? total : stop_after;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_request(gef_pkg::REQ_DRAIN, rand_byte(), rand_byte(), rand_byte());
      if (hold_midway && k == total / 2) wait_for_results();
      send_request(gef_pkg::REQ_PIXEL, rand_byte(), rand_byte(), rand_byte());
    end
    finished = (count == total);
    if (finished) begin
      for (int k = 0; k <= w; k++)
        send_request(($urandom_range(0, 99) < 4 * noise_pct) ?
                     gef_pkg::REQ_PIXEL : gef_pkg::REQ_DRAIN,
                     rand_byte(), rand_byte(), rand_byte());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry reads back as 1024 x 768; a few pixels release nothing
  task automatic test_reset_geometry();
    logic [31:0] value;
    read_register(gef_pkg::REG_FRAME_WIDTH, value);
    if (value !== 32'd1024) begin
      $error("frame_width: expected %0d, actual %0d", 1024, value);
      error_count++;
    end
    read_register(gef_pkg::REG_FRAME_HEIGHT, value);
    if (value !== 32'd768) begin
      $error("frame_height: expected %0d, actual %0d", 768, value);
      error_count++;
    end
    for (int k = 0; k < 8; k++)
      send_request(gef_pkg::REQ_PIXEL, rand_byte(), rand_byte(), rand_byte());
    settle_block();
  endtask

  // 3x2 frame with saturated and black pixels, an early drain, a pixel inside
  // the drain, a stray drain after the end, then zero width/height as 1x1
  task automatic test_corner_cases();
    write_register(gef_pkg::REG_FRAME_WIDTH, 32'd3);
    write_register(gef_pkg::REG_FRAME_HEIGHT, 32'd2);
    send_request(gef_pkg::REQ_DRAIN, 8'hff, 8'hff, 8'hff);     // early drain, ignored
    send_request(gef_pkg::REQ_PIXEL, 8'hff, 8'hff, 8'hff);
    send_request(gef_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00);
    send_request(gef_pkg::REQ_PIXEL, 8'hff, 8'h00, 8'h00);
    send_request(gef_pkg::REQ_PIXEL, 8'h00, 8'hff, 8'h00);
    send_request(gef_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'hff);
    send_request(gef_pkg::REQ_PIXEL, 8'hff, 8'hff, 8'hff);
    send_request(gef_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00);
    send_request(gef_pkg::REQ_DRAIN, 8'h5a, 8'ha5, 8'h3c);
    send_request(gef_pkg::REQ_PIXEL, 8'haa, 8'h55, 8'haa);     // counts as a drain
    send_request(gef_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00);     // last_of_frame
    send_request(gef_pkg::REQ_DRAIN, 8'hff, 8'hff, 8'hff);     // new frame, ignored
    settle_block();
    write_register(gef_pkg::REG_FRAME_WIDTH, 32'd0);
    write_register(gef_pkg::REG_FRAME_HEIGHT, 32'd0);
    send_request(gef_pkg::REQ_PIXEL, 8'h80, 8'h7f, 8'h01);
    send_request(gef_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00);
    send_request(gef_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00);
    settle_block();
  endtask

  // Oversize width and height saturate: a cut-short frame just past one
  // full row gives the first results at 1024 columns. Then a small frame
  // that pauses midway until every result is out.
  task automatic test_extreme_geometry();
    bit done;
    write_register(gef_pkg::REG_FRAME_WIDTH, field_word(2047, gef_pkg::WIDTH_W));
    write_register(gef_pkg::REG_FRAME_HEIGHT, field_word(8191, gef_pkg::HEIGHT_W));
    stream_frame(gef_pkg::MAX_WIDTH + 4, 0, 1'b0, done);
    settle_block();
    write_register(gef_pkg::REG_FRAME_WIDTH, 32'd2);
    write_register(gef_pkg::REG_FRAME_HEIGHT, 32'd3);
    stream_frame(-1, 0, 1'b1, done);
    settle_block();
  endtask

  // Mostly small random frames; some cut short, some with noise. The first
  // stretch runs with no idling on either side.
  task automatic test_random_frames();
    int base, w, h, pick, noise, stop;
    bit done;
    base    = accepted_items;
    done    = 1'b0;
    idle_on = 1'b0;
    while (accepted_items - base < RANDOM_ITEMS) begin
      if (accepted_items - base > QUIET_ITEMS) idle_on = 1'b1;
      // a cut-short frame must be restarted by a write
      if (!done || $urandom_range(0, 3) != 0) begin
        settle_block();
        pick = $urandom_range(0, 19);
        if (pick == 0) w = 0;
        else if (pick == 1) w = $urandom_range(17, 80);
        else w = $urandom_range(1, 16);
        h = (w > 16) ? $urandom_range(1, 4) : $urandom_range(1, 10);
        if ($urandom_range(0, 14) == 0) h = 0;
        pick = $urandom_range(0, 3);
        if (pick != 1) write_register(gef_pkg::REG_FRAME_WIDTH, field_word(w, gef_pkg::WIDTH_W));
        if (pick != 0)
          write_register(gef_pkg::REG_FRAME_HEIGHT, field_word(h, gef_pkg::HEIGHT_W));
      end
      noise = ($urandom_range(0, 3) == 0) ? 0 : 5;
      stop  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 40)) : -1;
      stream_frame(stop, noise, $urandom_range(0, 7) == 0, done);
      if (done && $urandom_range(0, 9) == 0)
        send_request(gef_pkg::REQ_DRAIN, rand_byte(), rand_byte(), rand_byte());
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_emboss.size() == 0) begin
        $error("unexpected result: emboss_value %0d last_of_frame %0d",
               emboss_value, last_of_frame);
        error_count++;
      end else begin
        want = expected_emboss.pop_front();
        if (emboss_value !== want.value) begin
          $error("emboss_value: expected %0d, actual %0d", want.value, emboss_value);
          error_count++;
        end
        if (last_of_frame !== want.last) begin
          $error("last_of_frame: expected %0d, actual %0d", want.last, last_of_frame);
          error_count++;
        end
      end
    end
    res_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[gray_emboss_3x3_filter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_corner_cases();
    test_extreme_geometry();
    test_random_frames();
    settle_block();
    if (error_count == 0 && expected_emboss.size() == 0) begin
      $display("[gray_emboss_3x3_filter] OK");
    end else begin
      $display("[gray_emboss_3x3_filter] ERROR");
    end
    $finish;
  end

endmodule
